/* rtl/fbc_pkg.sv */
// Shared constants, result codes and pipeline control types for the frustum box test.
package fbc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int PLANE_WIDTH     = 4 * COEF_WIDTH;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_AXES        = 3;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [1:0] {
        RES_DISJOINT   = 2'd0,
        RES_INTERSECTS = 2'd1,
        RES_CONTAINS   = 2'd2
    } containment_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fbc_stage_en_t;

endpackage

/* rtl/fbc_plane_eval.sv */
// Three-stage evaluation of one plane against a box: products, per-axis extremes, signs.
module fbc_plane_eval #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  fbc_pkg::fbc_stage_en_t              stage_en,
    input  logic [fbc_pkg::PLANE_WIDTH-1:0]     plane_coef,
    input  logic signed [COORD_WIDTH-1:0]       lo_x,
    input  logic signed [COORD_WIDTH-1:0]       lo_y,
    input  logic signed [COORD_WIDTH-1:0]       lo_z,
    input  logic signed [COORD_WIDTH-1:0]       hi_x,
    input  logic signed [COORD_WIDTH-1:0]       hi_y,
    input  logic signed [COORD_WIDTH-1:0]       hi_z,
    output logic                                all_out,
    output logic                                some_out
);
    import fbc_pkg::*;

    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int SW = PW + 2;

    logic signed [COEF_WIDTH-1:0]  coef [NUM_AXES];
    logic signed [COEF_WIDTH-1:0]  coef_d;
    logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];

    logic signed [PW-1:0] prod_lo_reg [NUM_AXES];
    logic signed [PW-1:0] prod_hi_reg [NUM_AXES];
    logic signed [PW-1:0] max_reg [NUM_AXES];
    logic signed [PW-1:0] min_reg [NUM_AXES];
    logic                 max_neg_reg;
    logic                 min_neg_reg;

    logic signed [SW-1:0] sum_max;
    logic signed [SW-1:0] sum_min;

    assign coef[0] = plane_coef[COEF_WIDTH-1:0];
    assign coef[1] = plane_coef[2*COEF_WIDTH-1:COEF_WIDTH];
    assign coef[2] = plane_coef[3*COEF_WIDTH-1:2*COEF_WIDTH];
    assign coef_d  = plane_coef[4*COEF_WIDTH-1:3*COEF_WIDTH];

    assign lo[0] = lo_x;
    assign lo[1] = lo_y;
    assign lo[2] = lo_z;
    assign hi[0] = hi_x;
    assign hi[1] = hi_y;
    assign hi[2] = hi_z;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (stage_en.s1) begin
                prod_lo_reg[k] <= PW'(coef[k]) * PW'(lo[k]);
                prod_hi_reg[k] <= PW'(coef[k]) * PW'(hi[k]);
            end
            if (stage_en.s2) begin
                if (prod_hi_reg[k] > prod_lo_reg[k]) begin
                    max_reg[k] <= prod_hi_reg[k];
                    min_reg[k] <= prod_lo_reg[k];
                end else begin
                    max_reg[k] <= prod_lo_reg[k];
                    min_reg[k] <= prod_hi_reg[k];
                end
            end
        end
    end

    assign sum_max = SW'(max_reg[0]) + SW'(max_reg[1]) + SW'(max_reg[2]) + SW'(coef_d);
    assign sum_min = SW'(min_reg[0]) + SW'(min_reg[1]) + SW'(min_reg[2]) + SW'(coef_d);

    always_ff @(posedge aclk) begin
        if (stage_en.s3) begin
            max_neg_reg <= sum_max[SW-1];
            min_neg_reg <= sum_min[SW-1];
        end
    end

    assign all_out  = max_neg_reg;
    assign some_out = min_neg_reg;

endmodule

/* rtl/frustum_box_containment.sv */
// Top level of the frustum versus axis-aligned box containment test.
//
// Each transaction carries a box (min and max corners); the block returns one
// containment code per box: disjoint, intersects or contains, tested against
// six planes written through the configuration port (a,b,c,d packed as signed
// 16-bit values, a in the low bits). Per plane the largest and smallest value
// of a*x+b*y+c*z+d over the eight corners comes from picking, per axis, the
// larger or smaller product, so the result is exact. One box is taken every
// cycle unless a stalled output has filled the pipeline; the result register
// loads through the multiplier, extreme select, sum and classify register
// stages. Stages advance independently, so bubbles collapse while the output
// is stalled. Write the planes only while no transaction is in flight.
module frustum_box_containment #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [fbc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [fbc_pkg::PLANE_WIDTH-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_min_x,
    input  logic signed [COORD_WIDTH-1:0]         s_min_y,
    input  logic signed [COORD_WIDTH-1:0]         s_min_z,
    input  logic signed [COORD_WIDTH-1:0]         s_max_x,
    input  logic signed [COORD_WIDTH-1:0]         s_max_y,
    input  logic signed [COORD_WIDTH-1:0]         s_max_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_containment
);
    import fbc_pkg::*;

    logic [PLANE_WIDTH-1:0] plane_reg [NUM_PLANES];

    logic v1_reg, v2_reg, v3_reg;
    logic m_valid_reg;
    containment_t containment_reg;
    containment_t containment_next;

    logic en1, en2, en3, en4;
    fbc_stage_en_t stage_en;

    logic [NUM_PLANES-1:0] all_out;
    logic [NUM_PLANES-1:0] some_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                plane_reg[p] <= '0;
            end
        end else if (cfg_wen && (cfg_index < CFG_INDEX_WIDTH'(NUM_PLANES))) begin
            plane_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign en4 = !m_valid_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign stage_en.s1 = en1;
    assign stage_en.s2 = en2;
    assign stage_en.s3 = en3;

    assign s_ready = en1;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fbc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane (
            .aclk       (aclk),
            .stage_en   (stage_en),
            .plane_coef (plane_reg[p]),
            .lo_x       (s_min_x),
            .lo_y       (s_min_y),
            .lo_z       (s_min_z),
            .hi_x       (s_max_x),
            .hi_y       (s_max_y),
            .hi_z       (s_max_z),
            .all_out    (all_out[p]),
            .some_out   (some_out[p])
        );
    end

    always_comb begin
        if (|all_out) begin
            containment_next = RES_DISJOINT;
        end else if (|some_out) begin
            containment_next = RES_INTERSECTS;
        end else begin
            containment_next = RES_CONTAINS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            containment_reg <= containment_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_containment = containment_reg;

endmodule

/* tb/sv/tb_frustum_box_containment.sv */
// Self-checking testbench for frustum_box_containment: directed and random boxes.
module tb_frustum_box_containment;
    import fbc_pkg::*;

    localparam int W           = COORD_WIDTH_DEF;
    localparam int NUM_CORNERS = 8;
    localparam int SETTLE      = 20;
    localparam int HOLD_OFF    = 200;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR,
        REG_SPARE0, REG_SPARE1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] d, c, b, a;
    } plane_t;

    // lo[0..2] is min x,y,z and hi[0..2] is max x,y,z
    typedef struct packed {
        logic [NUM_AXES-1:0][W-1:0] hi;
        logic [NUM_AXES-1:0][W-1:0] lo;
    } box_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_wen       = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index     = '0;
    logic [PLANE_WIDTH-1:0]      cfg_wdata     = '0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [W-1:0]         s_min_x       = '0;
    logic signed [W-1:0]         s_min_y       = '0;
    logic signed [W-1:0]         s_min_z       = '0;
    logic signed [W-1:0]         s_max_x       = '0;
    logic signed [W-1:0]         s_max_y       = '0;
    logic signed [W-1:0]         s_max_z       = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [1:0]                  m_containment;

    plane_t       planes [NUM_PLANES];
    containment_t containment_q [$];
    containment_t exp_c;
    int           n_errors    = 0;
    int           hold_req    = 0;
    bit           tx_idle_on  = 1'b1;
    bit           rx_stall_on = 1'b1;

    frustum_box_containment #(.COORD_WIDTH(W)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic containment_t classify_box(box_t bx);
        longint lo [NUM_AXES];
        longint hi [NUM_AXES];
        longint x, y, z, s;
        int     n_out;
        bit     culled;
        bit     all_in;
        culled = 1'b0;
        all_in = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            lo[k] = longint'(signed'(bx.lo[k]));
            hi[k] = longint'(signed'(bx.hi[k]));
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_out = 0;
            for (int j = 0; j < NUM_CORNERS; j++) begin
                x = ((j & 1) != 0) ? hi[0] : lo[0];
                y = ((j & 2) != 0) ? hi[1] : lo[1];
                z = ((j & 4) != 0) ? hi[2] : lo[2];
                s = longint'(planes[p].a) * x + longint'(planes[p].b) * y
                  + longint'(planes[p].c) * z + longint'(planes[p].d);
                if (s < 0) n_out++;
            end
            if (n_out == NUM_CORNERS) culled = 1'b1;
            else if (n_out > 0) all_in = 1'b0;
        end
        if (culled) return RES_DISJOINT;
        if (all_in) return RES_CONTAINS;
        return RES_INTERSECTS;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic box_t mk_box(int xl, int yl, int zl, int xh, int yh, int zh);
        box_t bx;
        bx.lo[0] = xl[W-1:0];
        bx.lo[1] = yl[W-1:0];
        bx.lo[2] = zl[W-1:0];
        bx.hi[0] = xh[W-1:0];
        bx.hi[1] = yh[W-1:0];
        bx.hi[2] = zh[W-1:0];
        return bx;
    endfunction

    // span <= 8000 keeps every corner inside the 16-bit range
    function automatic box_t rand_box(int span);
        box_t bx;
        int   c, e, lo, hi, t;
        if ($urandom_range(0, 99) < 15) begin
            bx = {$urandom, $urandom, $urandom};
            return bx;
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            c  = int'($urandom_range(0, 4 * span)) - 2 * span;
            e  = $urandom_range(0, span);
            lo = c - e;
            hi = c + e;
            if ($urandom_range(0, 9) == 0) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            bx.lo[k] = lo[W-1:0];
            bx.hi[k] = hi[W-1:0];
        end
        return bx;
    endfunction

    task automatic send_box(box_t bx);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 99) >= 60) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_min_x <= bx.lo[0];
        s_min_y <= bx.lo[1];
        s_min_z <= bx.lo[2];
        s_max_x <= bx.hi[0];
        s_max_y <= bx.hi[1];
        s_max_z <= bx.hi[2];
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        containment_q.push_back(classify_box(bx));
    endtask

    // drop valid, wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (containment_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [PLANE_WIDTH-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx < NUM_PLANES) planes[idx] = data;
    endtask

    task automatic cfg_done();
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    // axis-aligned box frustum of half-size r, optionally tilted and scaled
    task automatic load_cube(int r, bit tilt);
        plane_t pl;
        int     k;
        for (int p = 0; p < NUM_PLANES; p++) begin
            k  = tilt ? $urandom_range(1, 4) : 1;
            pl = '0;
            if (tilt) begin
                pl.a = COEF_WIDTH'(int'($urandom_range(0, 2)) - 1);
                pl.b = COEF_WIDTH'(int'($urandom_range(0, 2)) - 1);
                pl.c = COEF_WIDTH'(int'($urandom_range(0, 2)) - 1);
            end
            case (p / 2)
                0: pl.a = COEF_WIDTH'((p % 2) ? -k : k);
                1: pl.b = COEF_WIDTH'((p % 2) ? -k : k);
                default: pl.c = COEF_WIDTH'((p % 2) ? -k : k);
            endcase
            pl.d = COEF_WIDTH'(k * r);
            cfg_write(cfg_reg_t'(p), pl);
        end
        cfg_done();
    endtask

    task automatic test_reset_planes();
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        repeat (3) send_box(rand_box(8000));
    endtask

    task automatic test_directed_cube();
        drain();
        load_cube(100, 1'b0);
        send_box(mk_box(-50, -50, -50, 50, 50, 50));
        send_box(mk_box(-100, -100, -100, 100, 100, 100));
        send_box(mk_box(-101, -100, -100, 100, 100, 100));
        send_box(mk_box(-100, -100, -100, 100, 100, 101));
        send_box(mk_box(200, -10, -10, 300, 10, 10));
        send_box(mk_box(-10, -10, -300, 10, 10, -101));
        send_box(mk_box(50, 50, 50, -50, -50, -50));
        send_box(mk_box(150, 0, 0, 50, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        drain();
        cfg_write(PLANE_FAR, '0);
        cfg_done();
        send_box(mk_box(0, 0, 5000, 10, 10, 32767));
        send_box(mk_box(0, 0, -5000, 10, 10, -200));
        drain();
        cfg_write(REG_SPARE0, '1);
        cfg_write(REG_SPARE1, {4{16'h8000}});
        cfg_done();
        send_box(mk_box(0, 0, 5000, 10, 10, 32767));
        send_box(mk_box(-50, -50, -50, 50, 50, 50));
    endtask

    task automatic test_random_cubes();
        int r;
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: r = 4;
                4: r = 8000;
                default: r = $urandom_range(16, 6000);
            endcase
            load_cube(r, ph >= 2);
            tx_idle_on  = (ph != 1 && ph != 2);
            rx_stall_on = (ph != 1 && ph != 3);
            repeat (70) send_box(rand_box(r));
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_random_planes();
        for (int ph = 0; ph < 2; ph++) begin
            drain();
            for (int p = 0; p < NUM_PLANES; p++) cfg_write(cfg_reg_t'(p), {$urandom, $urandom});
            cfg_done();
            repeat (40) send_box(rand_box(8000));
        end
    endtask

    task automatic test_extreme_planes();
        plane_t pl;
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            for (int p = 0; p < NUM_PLANES; p++) begin
                case (ph)
                    0: pl = {4{16'h8000}};
                    1: pl = {4{16'h7fff}};
                    default: begin
                        pl.a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                        pl.b = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                        pl.c = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                        pl.d = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    end
                endcase
                cfg_write(cfg_reg_t'(p), pl);
            end
            cfg_done();
            send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
            send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
            send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
            repeat (12) send_box(rand_box(8000));
        end
    endtask

    task automatic test_output_hold_off();
        drain();
        load_cube($urandom_range(500, 4000), 1'b1);
        tx_idle_on = 1'b0;
        hold_req   = HOLD_OFF;
        repeat (40) send_box(rand_box(2000));
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (20) send_box(rand_box(2000));
        drain();
        repeat (20) send_box(rand_box(2000));
    endtask

    initial begin : receiver
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (containment_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected transaction, expected none, actual %0d",
                         $time, m_containment);
            end else begin
                exp_c = containment_q.pop_front();
                if (m_containment !== exp_c) begin
                    n_errors++;
                    $display("%0t: containment mismatch, expected %0d, actual %0d",
                             $time, exp_c, m_containment);
                end
            end
        end
    end

    initial begin
        for (int p = 0; p < NUM_PLANES; p++) planes[p] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_planes();
        test_directed_cube();
        test_random_cubes();
        test_random_planes();
        test_extreme_planes();
        test_output_hold_off();
        test_sender_pause();
        drain();
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fbc_pkg.sv
rtl/fbc_plane_eval.sv
rtl/frustum_box_containment.sv
tb/sv/tb_frustum_box_containment.sv
